// ===== hdl/vtp_pkg.sv =====
// Shared types, codes and constants for the VGA test pattern pixel block.
package vtp_pkg;

   // Port widths.
   localparam int REQ_W  = 48;  // column 12 + line 10 + frame 16 + pixel 9, padded to bytes
   localparam int RSP_W  = 16;  // color 8 + visible 1, padded to bytes
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 12;

   // Field widths.
   localparam int COL_W   = 12;
   localparam int LINE_W  = 10;
   localparam int FRAME_W = 16;
   localparam int PX_W    = 9;
   localparam int COLOR_W = 8;
   localparam int BIN_W   = 9;

   // Quotient bits resolved per stage of the pixel index divider.
   localparam int PX_STEPS = 3;

   // Pattern modes.
   typedef enum logic [2:0] {
      MODE_HSTRIPE  = 3'd0,
      MODE_VSTRIPE  = 3'd1,
      MODE_BINNED   = 3'd2,
      MODE_CHESS    = 3'd3,
      MODE_MUL_XOR  = 3'd4,
      MODE_MUL_PROD = 3'd5
   } vtp_mode_type;

   // Register indexes.
   localparam logic [CSR_AW-1:0] CSR_PATTERN_MODE  = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_SHIFT_BASE    = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_BIN_COUNT     = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_FIRST_VISIBLE = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_LAST_VISIBLE  = 3'd4;

   // Reset values.
   localparam logic [2:0]        RST_PATTERN_MODE  = 3'd0;
   localparam logic [4:0]        RST_SHIFT_BASE    = 5'd10;
   localparam logic [BIN_W-1:0]  RST_BIN_COUNT     = 9'd12;
   localparam logic [COL_W-1:0]  RST_FIRST_VISIBLE = 12'd600;
   localparam logic [COL_W-1:0]  RST_LAST_VISIBLE  = 12'd3900;

   // Reciprocals for line/40 and line/24, exact over a 10-bit line number.
   localparam logic [10:0] DIV40_MUL = 11'd1639;
   localparam logic [11:0] DIV24_MUL = 12'd2731;

   // Shift offsets for the multiply patterns; shift saturates at 31.
   localparam logic [5:0] SHIFT4_OFS = 6'd5;
   localparam logic [5:0] SHIFT5_OFS = 6'd14;
   localparam logic [4:0] SHIFT_SAT  = 5'd31;

   function automatic logic [COLOR_W-1:0] palette(input logic [2:0] idx);
      logic [COLOR_W-1:0] c;
      case (idx)
         3'd0:    c = 8'h00;
         3'd1:    c = 8'h07;
         3'd2:    c = 8'h3F;
         3'd3:    c = 8'h38;
         3'd4:    c = 8'hF8;
         3'd5:    c = 8'h0F;
         3'd6:    c = 8'hC0;
         3'd7:    c = 8'hFF;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/vga_test_pattern_pixel.sv =====
// Top level of the VGA test pattern pixel generator: six-stage pixel pipeline.
//
// Usage notes:
//  - req_* carries one pixel word per handshake: column counter, line, frame and
//    pixel index. rsp_* returns one word per pixel: 8-bit color and visible flag.
//  - csr_* writes the five setup registers (mode, shift base, bin count, window
//    bounds); write them only while no pixel is in flight.
//  - A word taken on req passes through the six registered stages before it
//    leaves on rsp; throughput is one word per cycle while rsp is not stalled.
//    Stage 1 registers the input decode and small products, stage 2 the 16x32
//    frame multiply, stage 3 the arithmetic shift, stages 4-6 the
//    pixel-index / bin-size divide, 3 quotient bits per stage.
//  - Bin size (LINE_PIXELS / bin_count) comes from a free-running two-stage
//    divider on the bin_count register; after a write it settles ahead of any
//    pixel reaching stage 4.
//  - Each stage has its own valid bit and ready; a stalled rsp side fills the
//    empty stages first, then drops req_tready. Nothing is lost or repeated.
//  - Reset (synchronous, active high) empties the pipeline, loads register
//    defaults and holds req_tready low.
module vga_test_pattern_pixel #(
   parameter int LINE_PIXELS = 320
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [11:0] column_count, [21:12] line_number, [37:22] frame_number,
   // [46:38] pixel_index, [47] zero pad
   input  logic [vtp_pkg::REQ_W-1:0]    req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [7:0] pixel_color, [8] pixel_visible, [15:9] zero
   output logic [vtp_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                         csr_we,
   input  logic [vtp_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [vtp_pkg::CSR_DW-1:0]   csr_wdata
);

   localparam int NW = $clog2(LINE_PIXELS + 1);   // bin size width
   localparam int H1 = (NW + 1) / 2;              // bin divider, first half
   localparam int H2 = NW - H1;                   // bin divider, second half
   localparam logic [NW-1:0] LINE_NUM = NW'(LINE_PIXELS);

   localparam int CW = vtp_pkg::COLOR_W;
   localparam int PW = vtp_pkg::PX_W;
   localparam int PS = vtp_pkg::PX_STEPS;

   // ---------------- setup registers ----------------
   logic [2:0]                  mode_ff;
   logic [4:0]                  shift_base_ff;
   logic [vtp_pkg::BIN_W-1:0]   bin_count_ff;
   logic [vtp_pkg::COL_W-1:0]   first_vis_ff;
   logic [vtp_pkg::COL_W-1:0]   last_vis_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= vtp_pkg::RST_PATTERN_MODE;
         shift_base_ff <= vtp_pkg::RST_SHIFT_BASE;
         bin_count_ff  <= vtp_pkg::RST_BIN_COUNT;
         first_vis_ff  <= vtp_pkg::RST_FIRST_VISIBLE;
         last_vis_ff   <= vtp_pkg::RST_LAST_VISIBLE;
      end else if (csr_we) begin
         case (csr_addr)
            vtp_pkg::CSR_PATTERN_MODE:  mode_ff       <= csr_wdata[2:0];
            vtp_pkg::CSR_SHIFT_BASE:    shift_base_ff <= csr_wdata[4:0];
            vtp_pkg::CSR_BIN_COUNT:     bin_count_ff  <= csr_wdata[8:0];
            vtp_pkg::CSR_FIRST_VISIBLE: first_vis_ff  <= csr_wdata;
            vtp_pkg::CSR_LAST_VISIBLE:  last_vis_ff   <= csr_wdata;
            default: ;  // unknown index, ignored
         endcase
      end
   end

   // ---------------- bin size = LINE_PIXELS / bin_count ----------------
   // Free running; the user must change bin_count only while idle (not enforced here).
   logic [vtp_pkg::BIN_W-1:0] brem_in;
   logic [vtp_pkg::BIN_W-1:0] brem_ff;
   logic [H1-1:0]             bq_hi_in;
   logic [H1-1:0]             bq_hi_ff;
   logic [H2-1:0]             bq_lo_in;
   logic [NW-1:0]             bin_size_ff;

   vtp_div_stage #(.DW(vtp_pkg::BIN_W), .STEPS(H1)) u_bin_div_hi (
      .num_bits (LINE_NUM[NW-1 -: H1]),
      .rem_in   ('0),
      .divisor  (bin_count_ff),
      .rem_out  (brem_in),
      .quo      (bq_hi_in)
   );

   vtp_div_stage #(.DW(vtp_pkg::BIN_W), .STEPS(H2)) u_bin_div_lo (
      .num_bits (LINE_NUM[H2-1:0]),
      .rem_in   (brem_ff),
      .divisor  (bin_count_ff),
      .rem_out  (),
      .quo      (bq_lo_in)
   );

   always_ff @(posedge clock) begin
      brem_ff     <= brem_in;
      bq_hi_ff    <= bq_hi_in;
      bin_size_ff <= {bq_hi_ff, bq_lo_in};
   end

   // ---------------- pipeline control ----------------
   logic [6:1] stg_v_ff;
   logic [6:1] rdy;

   always_comb begin
      rdy[6] = !stg_v_ff[6] || rsp_tready;
      rdy[5] = !stg_v_ff[5] || rdy[6];
      rdy[4] = !stg_v_ff[4] || rdy[5];
      rdy[3] = !stg_v_ff[3] || rdy[4];
      rdy[2] = !stg_v_ff[2] || rdy[3];
      rdy[1] = !stg_v_ff[1] || rdy[2];
   end

   assign req_tready = rdy[1] && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_v_ff <= '0;
      end else begin
         if (rdy[1]) stg_v_ff[1] <= req_tvalid;
         if (rdy[2]) stg_v_ff[2] <= stg_v_ff[1];
         if (rdy[3]) stg_v_ff[3] <= stg_v_ff[2];
         if (rdy[4]) stg_v_ff[4] <= stg_v_ff[3];
         if (rdy[5]) stg_v_ff[5] <= stg_v_ff[4];
         if (rdy[6]) stg_v_ff[6] <= stg_v_ff[5];
      end
   end

   // ---------------- stage 1: decode, small products ----------------
   logic [vtp_pkg::COL_W-1:0]   col;
   logic [vtp_pkg::LINE_W-1:0]  line;
   logic [vtp_pkg::FRAME_W-1:0] frame;
   logic [PW-1:0]               px;

   assign col   = req_tdata[11:0];
   assign line  = req_tdata[21:12];
   assign frame = req_tdata[37:22];
   assign px    = req_tdata[46:38];

   logic [20:0]   m5a;      // (col/2) * line
   logic [20:0]   m40;      // line * 1639, line/40 in [20:16]
   logic [21:0]   m24;      // line * 2731, line/24 in [21:16]
   logic [31:0]   op_in;
   logic [CW-1:0] ecolor_in;
   logic          vis_in;

   assign m5a    = col[11:1] * line;
   assign m40    = line * vtp_pkg::DIV40_MUL;
   assign m24    = line * vtp_pkg::DIV24_MUL;
   assign vis_in = (col >= first_vis_ff) && (col < last_vis_ff);

   always_comb begin
      // mode 4 operand is (col/2) xor ~line over 32 bits
      if (mode_ff == vtp_pkg::MODE_MUL_XOR) begin
         op_in = {22'h3FFFFF, ~line} ^ {21'd0, col[11:1]};
      end else begin
         op_in = {11'd0, m5a};
      end
      case (mode_ff)
         vtp_pkg::MODE_HSTRIPE: ecolor_in = vtp_pkg::palette(line[8:6]);
         vtp_pkg::MODE_VSTRIPE: ecolor_in = vtp_pkg::palette(col[10:8]);
         vtp_pkg::MODE_CHESS:   ecolor_in = (m24[16] ^ col[2]) ? 8'hFF : 8'h00;
         default:               ecolor_in = 8'h00;
      endcase
   end

   logic [31:0]                 s1_op_ff;
   logic [vtp_pkg::FRAME_W-1:0] s1_frame_ff;
   logic [PW-1:0]               s1_px_ff;
   logic [1:0]                  s1_cline_ff;
   logic [CW-1:0]               s1_color_ff;
   logic                        s1_vis_ff;

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_op_ff    <= op_in;
         s1_frame_ff <= frame;
         s1_px_ff    <= px;
         s1_cline_ff <= m40[17:16];
         s1_color_ff <= ecolor_in;
         s1_vis_ff   <= vis_in;
      end
   end

   // ---------------- stage 2: frame multiply ----------------
   logic [47:0] prod_w;
   assign prod_w = s1_frame_ff * s1_op_ff;

   logic [31:0]   s2_prod_ff;
   logic [PW-1:0] s2_px_ff;
   logic [1:0]    s2_cline_ff;
   logic [CW-1:0] s2_color_ff;
   logic          s2_vis_ff;

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s2_prod_ff  <= prod_w[31:0];
         s2_px_ff    <= s1_px_ff;
         s2_cline_ff <= s1_cline_ff;
         s2_color_ff <= s1_color_ff;
         s2_vis_ff   <= s1_vis_ff;
      end
   end

   // ---------------- stage 3: arithmetic shift ----------------
   logic [5:0]         sh_sum;
   logic [4:0]         sh_amt;
   logic signed [31:0] prod_s;
   logic signed [31:0] shifted;
   logic [CW-1:0]      color3_in;

   assign sh_sum  = {1'b0, shift_base_ff} + ((mode_ff == vtp_pkg::MODE_MUL_XOR) ?
                    vtp_pkg::SHIFT4_OFS : vtp_pkg::SHIFT5_OFS);
   assign sh_amt  = sh_sum[5] ? vtp_pkg::SHIFT_SAT : sh_sum[4:0];
   assign prod_s  = s2_prod_ff;
   assign shifted = prod_s >>> sh_amt;

   always_comb begin
      case (mode_ff)
         vtp_pkg::MODE_MUL_XOR,
         vtp_pkg::MODE_MUL_PROD: color3_in = shifted[7:0];
         default:                color3_in = s2_color_ff;
      endcase
   end

   logic [PW-1:0] s3_px_ff;
   logic [1:0]    s3_cline_ff;
   logic [CW-1:0] s3_color_ff;
   logic          s3_vis_ff;

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s3_px_ff    <= s2_px_ff;
         s3_cline_ff <= s2_cline_ff;
         s3_color_ff <= color3_in;
         s3_vis_ff   <= s2_vis_ff;
      end
   end

   // ---------------- stages 4-6: bin = pixel_index / bin size ----------------
   logic [NW-1:0] rem4_in;
   logic [PS-1:0] q4_in;

   vtp_div_stage #(.DW(NW), .STEPS(PS)) u_px_div_a (
      .num_bits (s3_px_ff[PW-1 -: PS]),
      .rem_in   ('0),
      .divisor  (bin_size_ff),
      .rem_out  (rem4_in),
      .quo      (q4_in)
   );

   logic [NW-1:0]    s4_rem_ff;
   logic [PS-1:0]    s4_k_ff;
   logic [PW-PS-1:0] s4_px_ff;
   logic [1:0]       s4_cline_ff;
   logic [CW-1:0]    s4_color_ff;
   logic             s4_vis_ff;

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s4_rem_ff   <= rem4_in;
         s4_k_ff     <= q4_in;
         s4_px_ff    <= s3_px_ff[PW-PS-1:0];
         s4_cline_ff <= s3_cline_ff;
         s4_color_ff <= s3_color_ff;
         s4_vis_ff   <= s3_vis_ff;
      end
   end

   logic [NW-1:0] rem5_in;
   logic [PS-1:0] q5_in;

   vtp_div_stage #(.DW(NW), .STEPS(PS)) u_px_div_b (
      .num_bits (s4_px_ff[PW-PS-1 -: PS]),
      .rem_in   (s4_rem_ff),
      .divisor  (bin_size_ff),
      .rem_out  (rem5_in),
      .quo      (q5_in)
   );

   logic [NW-1:0]      s5_rem_ff;
   logic [2*PS-1:0]    s5_k_ff;
   logic [PW-2*PS-1:0] s5_px_ff;
   logic [1:0]         s5_cline_ff;
   logic [CW-1:0]      s5_color_ff;
   logic               s5_vis_ff;

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         s5_rem_ff   <= rem5_in;
         s5_k_ff     <= {s4_k_ff, q5_in};
         s5_px_ff    <= s4_px_ff[PW-2*PS-1:0];
         s5_cline_ff <= s4_cline_ff;
         s5_color_ff <= s4_color_ff;
         s5_vis_ff   <= s4_vis_ff;
      end
   end

   logic [PS-1:0] q6_in;

   vtp_div_stage #(.DW(NW), .STEPS(PS)) u_px_div_c (
      .num_bits (s5_px_ff),
      .rem_in   (s5_rem_ff),
      .divisor  (bin_size_ff),
      .rem_out  (),
      .quo      (q6_in)
   );

   // Mode 2: zero bin count, zero bin size, or a pixel past the last whole
   // bin all give black.
   logic [PW-1:0] bin_k;
   logic [2:0]    pal_idx;
   logic          bin_ok;
   logic [CW-1:0] color6_in;

   assign bin_k   = {s5_k_ff, q6_in};
   assign pal_idx = bin_k[2:0] + 3'd1 + {1'b0, s5_cline_ff};
   assign bin_ok  = (bin_count_ff != '0) && (bin_size_ff != '0) && (bin_k < bin_count_ff);

   always_comb begin
      if (!s5_vis_ff) begin
         color6_in = 8'h00;
      end else if (mode_ff == vtp_pkg::MODE_BINNED) begin
         color6_in = bin_ok ? vtp_pkg::palette(pal_idx) : 8'h00;
      end else begin
         color6_in = s5_color_ff;
      end
   end

   logic [CW-1:0] s6_color_ff;
   logic          s6_vis_ff;

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         s6_color_ff <= color6_in;
         s6_vis_ff   <= s5_vis_ff;
      end
   end

   assign rsp_tvalid = stg_v_ff[6];
   assign rsp_tdata  = {7'd0, s6_vis_ff, s6_color_ff};

   // ---------------- assertions ----------------
   // Input may only be taken while some stage has room or the output drains.
   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!(&stg_v_ff) || rsp_tready))
      else $error("req_tready with full pipeline and stalled output");

   // Pixels outside the window are always black.
   a_blank_outside: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[8]) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("nonzero color outside visible window");

   // An accepted word lands in stage 1.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> stg_v_ff[1])
      else $error("accepted word missing from stage 1");

endmodule

// ===== hdl/vtp_div_stage.sv =====
// A few restoring division steps: shifts in numerator bits, yields quotient bits.
module vtp_div_stage #(
   parameter int DW    = 9,
   parameter int STEPS = 3
) (
   input  logic [STEPS-1:0] num_bits,   // next numerator bits, MSB first
   input  logic [DW-1:0]    rem_in,
   input  logic [DW-1:0]    divisor,
   output logic [DW-1:0]    rem_out,
   output logic [STEPS-1:0] quo
);

   always_comb begin
      logic [DW:0]   trial;
      logic [DW-1:0] r;
      r = rem_in;
      for (int i = STEPS - 1; i >= 0; i--) begin
         trial = {r, num_bits[i]};
         if (trial >= {1'b0, divisor}) begin
            quo[i] = 1'b1;
            trial  = trial - {1'b0, divisor};
         end else begin
            quo[i] = 1'b0;
         end
         r = trial[DW-1:0];
      end
      rem_out = r;
   end

endmodule

// ===== tb/sv/tb_vga_test_pattern_pixel.sv =====
// Self-checking testbench for the VGA test pattern pixel generator.
module tb_vga_test_pattern_pixel;

   localparam int LINE_PIXELS = 320;
   localparam int RAND_PHASES = 24;
   localparam int HALF_PHASE  = 40;   // words per burst; a phase is two bursts
   localparam int MAX_REPORTS = 10;

   // Palette entries 0..7, entry 0 in the low byte.
   localparam logic [63:0] COLOR_TABLE =
      {8'hFF, 8'hC0, 8'h0F, 8'hF8, 8'h38, 8'h3F, 8'h07, 8'h00};

   // One pixel request word; declaration order puts column_count in the low bits.
   typedef struct packed {
      logic [vtp_pkg::PX_W-1:0]    px;
      logic [vtp_pkg::FRAME_W-1:0] frame;
      logic [vtp_pkg::LINE_W-1:0]  line;
      logic [vtp_pkg::COL_W-1:0]   col;
   } pixel_word_type;

   // One response word: color in the low byte, visible flag above it.
   typedef struct packed {
      logic                        visible;
      logic [vtp_pkg::COLOR_W-1:0] color;
   } pixel_result_type;

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   // [11:0] column_count, [21:12] line_number, [37:22] frame_number,
   // [46:38] pixel_index, [47] zero pad
   logic [vtp_pkg::REQ_W-1:0]   req_tdata;
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   // [7:0] pixel_color, [8] pixel_visible, [15:9] zero
   logic [vtp_pkg::RSP_W-1:0]   rsp_tdata;
   logic                        csr_we;
   logic [vtp_pkg::CSR_AW-1:0]  csr_addr;
   logic [vtp_pkg::CSR_DW-1:0]  csr_wdata;

   // Local copy of the setup registers, tracked as they are written.
   logic [2:0]                  cfg_mode;
   logic [4:0]                  cfg_shift;
   logic [vtp_pkg::BIN_W-1:0]   cfg_bins;
   logic [vtp_pkg::COL_W-1:0]   cfg_first;
   logic [vtp_pkg::COL_W-1:0]   cfg_last;

   pixel_word_type      pixel_pending[$];   // words waiting to be sent
   pixel_result_type    color_due[$];       // predicted responses, oldest first
   int                  mismatches;
   int                  send_idle_pct;
   int                  stall_pct;

   vga_test_pattern_pixel #(
      .LINE_PIXELS(LINE_PIXELS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Color and visible flag for one pixel under the current register copy.
   function automatic pixel_result_type predict_pixel(input pixel_word_type w);
      pixel_result_type   r;
      logic [31:0]        x;
      logic [31:0]        prod;
      logic signed [31:0] shifted;
      logic [5:0]         sh;
      int unsigned        bin_px;
      int unsigned        bin_k;
      int unsigned        band;
      r.visible = (w.col >= cfg_first) && (w.col < cfg_last);
      r.color   = '0;
      case (cfg_mode)
         vtp_pkg::MODE_HSTRIPE: r.color = COLOR_TABLE[w.line[8:6]*8 +: 8];
         vtp_pkg::MODE_VSTRIPE: r.color = COLOR_TABLE[w.col[10:8]*8 +: 8];
         vtp_pkg::MODE_BINNED: begin
            // zero bins, more bins than line pixels (bin size zero) and
            // pixels past the last whole bin all give black
            if (cfg_bins != 0) begin
               bin_px = LINE_PIXELS / cfg_bins;
               if (bin_px != 0) begin
                  bin_k = w.px / bin_px;
                  if (bin_k < cfg_bins) begin
                     band    = (w.line / 40) % 4;
                     r.color = COLOR_TABLE[((bin_k + 1 + band) % 8)*8 +: 8];
                  end
               end
            end
         end
         vtp_pkg::MODE_CHESS: begin
            band    = w.line / 24;
            r.color = (band[0] ^ w.col[2]) ? 8'hFF : 8'h00;
         end
         vtp_pkg::MODE_MUL_XOR: begin
            x       = {21'd0, w.col[11:1]} ^ ~{22'd0, w.line};
            prod    = {16'd0, w.frame} * x;
            sh      = {1'b0, cfg_shift} + 6'd5;
            if (sh > 6'd31) sh = 6'd31;   // shift saturates, sign fill
            shifted = $signed(prod) >>> sh;
            r.color = shifted[7:0];
         end
         vtp_pkg::MODE_MUL_PROD: begin
            x       = {21'd0, w.col[11:1]} * {22'd0, w.line};
            prod    = {16'd0, w.frame} * x;
            sh      = {1'b0, cfg_shift} + 6'd14;
            if (sh > 6'd31) sh = 6'd31;
            shifted = $signed(prod) >>> sh;
            r.color = shifted[7:0];
         end
         default: r.color = '0;   // modes 6 and 7 draw nothing
      endcase
      if (!r.visible) r.color = '0;
      return r;
   endfunction

   // Random pixel, biased toward field extremes and the window edges.
   function automatic pixel_word_type random_pixel();
      pixel_word_type w;
      case ($urandom_range(15))
         0:       w.col = '0;
         1:       w.col = '1;
         2:       w.col = cfg_first;
         3:       w.col = cfg_first - 1'b1;
         4:       w.col = cfg_last;
         5:       w.col = cfg_last - 1'b1;
         default: w.col = 12'($urandom_range(4095));
      endcase
      case ($urandom_range(7))
         0:       w.line = '0;
         1:       w.line = '1;
         default: w.line = 10'($urandom_range(1023));
      endcase
      case ($urandom_range(7))
         0:       w.frame = '0;
         1:       w.frame = '1;
         default: w.frame = 16'($urandom);
      endcase
      // pixel index mostly on the line, now and then past its end
      case ($urandom_range(15))
         0:       w.px = '0;
         1:       w.px = 9'(LINE_PIXELS - 1);
         2:       w.px = 9'($urandom_range(511, LINE_PIXELS));
         default: w.px = 9'($urandom_range(LINE_PIXELS - 1));
      endcase
      return w;
   endfunction

   // Register write, one per clock; the caller drops csr_we afterwards.
   task automatic write_reg(input logic [vtp_pkg::CSR_AW-1:0] idx,
                            input logic [vtp_pkg::CSR_DW-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         vtp_pkg::CSR_PATTERN_MODE:  cfg_mode  = val[2:0];
         vtp_pkg::CSR_SHIFT_BASE:    cfg_shift = val[4:0];
         vtp_pkg::CSR_BIN_COUNT:     cfg_bins  = val[vtp_pkg::BIN_W-1:0];
         vtp_pkg::CSR_FIRST_VISIBLE: cfg_first = val;
         vtp_pkg::CSR_LAST_VISIBLE:  cfg_last  = val;
         default: ;   // unmapped index, ignored by the block
      endcase
   endtask

   task automatic push_pixel(input int c, input int l, input int f, input int p);
      pixel_word_type w;
      w.col   = 12'(c);
      w.line  = 10'(l);
      w.frame = 16'(f);
      w.px    = 9'(p);
      pixel_pending.push_back(w);
   endtask

   // Wait at falling edges until nothing is queued, in flight or owed.
   task automatic wait_drained();
      @(negedge clock);
      while (pixel_pending.size() != 0 || req_tvalid || color_due.size() != 0)
         @(negedge clock);
   endtask

   // Sender: predicts each word as it is accepted, then offers the next one
   // unless it rolls an idle cycle.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            color_due.push_back(predict_pixel(pixel_word_type'(req_tdata[46:0])));
         if (!req_tvalid || req_tready) begin
            if (pixel_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {1'b0, pixel_pending.pop_front()};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each accepted response against the oldest prediction
   // and stalls at random.
   always @(posedge clock) begin
      pixel_result_type got;
      pixel_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[8:0];
            if (color_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected rsp word: color %h visible %b", got.color, got.visible);
            end else begin
               want = color_due.pop_front();
               if (got.color !== want.color || got.visible !== want.visible) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("pixel mismatch: expected color %h visible %b, got color %h visible %b",
                              want.color, want.visible, got.color, got.visible);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      int sel;
      int profile;
      logic [2:0]                mode_v;
      logic [4:0]                shift_v;
      logic [vtp_pkg::BIN_W-1:0] bins_v;
      logic [vtp_pkg::COL_W-1:0] first_v;
      logic [vtp_pkg::COL_W-1:0] last_v;

      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_we        = 1'b0;
      csr_addr      = '0;
      csr_wdata     = '0;
      mismatches    = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      cfg_mode      = vtp_pkg::RST_PATTERN_MODE;
      cfg_shift     = vtp_pkg::RST_SHIFT_BASE;
      cfg_bins      = vtp_pkg::RST_BIN_COUNT;
      cfg_first     = vtp_pkg::RST_FIRST_VISIBLE;
      cfg_last      = vtp_pkg::RST_LAST_VISIBLE;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed words under reset defaults (horizontal stripes, window
      // 600..3899): window edges, field extremes, one word per stripe.
      @(negedge clock);
      push_pixel(600, 0, 0, 0);
      push_pixel(599, 1023, 65535, 319);
      push_pixel(3899, 1023, 65535, 319);
      push_pixel(3900, 64, 1, 1);
      push_pixel(0, 0, 0, 0);
      push_pixel(4095, 1023, 65535, 511);
      for (int s = 0; s < 8; s++)
         push_pixel(700 + s * 300, s * 64 + 63, 16'h5A5A, s * 40);
      push_pixel(2048, 1023, 32768, 256);
      push_pixel(1365, 682, 43690, 170);
      wait_drained();

      for (int ph = 1; ph <= RAND_PHASES; ph++) begin
         // Pattern mode walks all eight codes, unused ones included.
         mode_v = 3'(ph % 8);

         sel = (ph <= 12) ? ph % 4 : $urandom_range(3);
         case (sel)
            0:       shift_v = 5'd0;
            1:       shift_v = 5'd16;
            2:       shift_v = 5'd31;   // saturated shift in both multiply modes
            default: shift_v = 5'($urandom_range(16));
         endcase

         sel = (ph <= 12) ? ph % 6 : $urandom_range(5);
         case (sel)
            0:       bins_v = 9'd0;
            1:       bins_v = 9'd1;
            2:       bins_v = 9'(LINE_PIXELS);
            3:       bins_v = 9'($urandom_range(511, LINE_PIXELS + 1));   // bin size zero
            4:       bins_v = 9'($urandom_range(40, 7));
            default: bins_v = 9'($urandom_range(1, LINE_PIXELS));
         endcase

         sel = (ph <= 10) ? ph % 5 : $urandom_range(4);
         case (sel)
            0: begin first_v = 12'd0;    last_v = 12'd4095; end
            1: begin first_v = 12'd4095; last_v = 12'd0;    end   // empty window
            2: begin
               first_v = 12'($urandom_range(4095));
               last_v  = first_v;                                 // empty window
            end
            3: begin
               first_v = 12'($urandom_range(4095));
               last_v  = 12'($urandom_range(4095));
            end
            default: begin
               first_v = 12'($urandom_range(1500));
               last_v  = 12'($urandom_range(4095, 2500));
            end
         endcase

         // Upper data bits carry junk; each register keeps only its width.
         write_reg(vtp_pkg::CSR_PATTERN_MODE,  {9'($urandom), mode_v});
         write_reg(vtp_pkg::CSR_SHIFT_BASE,    {7'($urandom), shift_v});
         write_reg(vtp_pkg::CSR_BIN_COUNT,     {3'($urandom), bins_v});
         write_reg(vtp_pkg::CSR_FIRST_VISIBLE, first_v);
         write_reg(vtp_pkg::CSR_LAST_VISIBLE,  last_v);
         // one write to an unmapped index; must not disturb anything
         write_reg(3'($urandom_range(7, vtp_pkg::CSR_LAST_VISIBLE + 1)), 12'($urandom));
         @(posedge clock);
         csr_we <= 1'b0;

         // Idle profile rotates so each pattern mode sees several of them.
         @(negedge clock);
         profile = (ph + ph / 8) % 4;
         case (profile)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 85; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 85; end
            default: begin send_idle_pct = 19; stall_pct = 19; end
         endcase

         // Two bursts; the sender holds off between them until every
         // response of the first burst is back.
         for (int half = 0; half < 2; half++) begin
            repeat (HALF_PHASE) pixel_pending.push_back(random_pixel());
            wait_drained();
         end
      end

      // Let any stray response surface before the verdict.
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/vtp_pkg.sv
hdl/vtp_div_stage.sv
hdl/vga_test_pattern_pixel.sv
tb/sv/tb_vga_test_pattern_pixel.sv
